// ===== hdl/sspr_pkg.sv =====
// shared types and constants for the servo speed ramp framer
`default_nettype none
package sspr_pkg;

   typedef enum logic [1:0] {
      OP_SET_TARGET = 2'd0,
      OP_SET_IMMEDIATE = 2'd1,
      OP_STOP = 2'd2,
      OP_RAMP_TICK = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_BUS_ADDR = 2'd0,
      CSR_RAMP_STEP = 2'd1,
      CSR_KEEPALIVE_MS = 2'd2,
      CSR_SPEED_MAX = 2'd3
   } csr_addr_type;

   localparam logic [7:0] SYNC_BYTE = 8'h55;
   localparam logic [7:0] FRAME_LEN = 8'd7;
   localparam logic [7:0] FRAME_CMD = 8'd29;
   localparam logic [7:0] FRAME_MODE = 8'd1;
   localparam logic [7:0] FRAME_PAD = 8'd0;

   localparam logic [7:0] RESET_BUS_ADDR = 8'd1;
   localparam logic [9:0] RESET_RAMP_STEP = 10'd40;
   localparam logic [15:0] RESET_KEEPALIVE_MS = 16'd80;
   localparam logic [14:0] RESET_SPEED_MAX = 15'd1000;

   localparam int FRAME_BYTES = 10;
   localparam int IDX_W = 4;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

   typedef struct packed {
      logic has_frame;
      logic signed [15:0] speed;
      logic [7:0] bus_addr;
      logic [7:0] csum;
   } job_type;

   // byte of the motor mode frame at position idx
   function automatic logic [7:0] frame_byte_at(job_type job, logic [IDX_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0: b = SYNC_BYTE;
         4'd1: b = SYNC_BYTE;
         4'd2: b = job.bus_addr;
         4'd3: b = FRAME_LEN;
         4'd4: b = FRAME_CMD;
         4'd5: b = FRAME_MODE;
         4'd6: b = FRAME_PAD;
         4'd7: b = job.speed[7:0];
         4'd8: b = job.speed[15:8];
         default: b = job.csum;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/sspr_front.sv =====
// command front end: config registers, speed state, ramp and keepalive decision
`default_nettype none
module sspr_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_wr_en,
   input wire logic [1:0] csr_addr,
   input wire logic [15:0] csr_wdata,
   input wire logic cmd_take,
   input wire logic [1:0] cmd_opcode,
   input wire logic signed [15:0] cmd_speed,
   input wire logic [31:0] cmd_now_ms,
   output sspr_pkg::job_type job
);
   import sspr_pkg::*;

   logic [7:0] bus_addr_ff;
   logic [9:0] ramp_step_ff;
   logic [15:0] keepalive_ms_ff;
   logic [14:0] speed_max_ff;

   logic signed [15:0] target_ff, target_in;
   logic signed [15:0] out_ff, out_in;
   logic valid_ff, valid_in;
   logic [31:0] last_send_ff, last_send_in;

   logic signed [16:0] lim_pos, lim_neg, cmd_wide;
   logic signed [15:0] cmd;
   logic signed [17:0] out_x, tgt_x, step_up, step_dn;
   logic [31:0] elapsed;
   logic send;
   logic [7:0] sum8;

   always_comb begin
      lim_pos = {2'b00, speed_max_ff};
      lim_neg = -lim_pos;
      cmd_wide = {cmd_speed[15], cmd_speed};
      if (cmd_wide > lim_pos) begin
         cmd = lim_pos[15:0];
      end else if (cmd_wide < lim_neg) begin
         cmd = lim_neg[15:0];
      end else begin
         cmd = cmd_speed;
      end
   end

   assign out_x = {{2{out_ff[15]}}, out_ff};
   assign tgt_x = {{2{target_ff[15]}}, target_ff};
   assign step_up = out_x + $signed({8'b0, ramp_step_ff});
   assign step_dn = out_x - $signed({8'b0, ramp_step_ff});
   assign elapsed = cmd_now_ms - last_send_ff;

   always_comb begin
      target_in = target_ff;
      out_in = out_ff;
      valid_in = valid_ff;
      send = 1'b0;
      case (op_type'(cmd_opcode))
         OP_SET_TARGET: begin
            target_in = cmd;
         end
         OP_SET_IMMEDIATE: begin
            target_in = cmd;
            // nonzero speeds of opposite sign only retarget
            if (!(out_ff != '0 && cmd != '0 && out_ff[15] != cmd[15])) begin
               out_in = cmd;
               valid_in = 1'b1;
               send = 1'b1;
            end
         end
         OP_STOP: begin
            target_in = '0;
            out_in = '0;
            valid_in = 1'b1;
            send = 1'b1;
         end
         default: begin
            if (out_ff < target_ff) begin
               out_in = (step_up > tgt_x) ? target_ff : step_up[15:0];
               valid_in = 1'b1;
               send = 1'b1;
            end else if (out_ff > target_ff) begin
               out_in = (step_dn < tgt_x) ? target_ff : step_dn[15:0];
               valid_in = 1'b1;
               send = 1'b1;
            end else if (!valid_ff) begin
               valid_in = 1'b1;
               send = 1'b1;
            end else begin
               send = (out_ff != '0) && (elapsed >= {16'b0, keepalive_ms_ff});
            end
         end
      endcase
      last_send_in = send ? cmd_now_ms : last_send_ff;
   end

   assign sum8 = bus_addr_ff + FRAME_LEN + FRAME_CMD + FRAME_MODE + FRAME_PAD
               + out_in[7:0] + out_in[15:8];

   always_comb begin
      job.has_frame = send;
      job.speed = out_in;
      job.bus_addr = bus_addr_ff;
      job.csum = ~sum8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_addr_ff <= RESET_BUS_ADDR;
         ramp_step_ff <= RESET_RAMP_STEP;
         keepalive_ms_ff <= RESET_KEEPALIVE_MS;
         speed_max_ff <= RESET_SPEED_MAX;
      end else if (csr_wr_en) begin
         case (csr_addr_type'(csr_addr))
            CSR_BUS_ADDR: bus_addr_ff <= csr_wdata[7:0];
            CSR_RAMP_STEP: ramp_step_ff <= csr_wdata[9:0];
            CSR_KEEPALIVE_MS: keepalive_ms_ff <= csr_wdata;
            CSR_SPEED_MAX: speed_max_ff <= csr_wdata[14:0];
            default: bus_addr_ff <= bus_addr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         out_ff <= '0;
         valid_ff <= 1'b0;
         last_send_ff <= '0;
      end else if (cmd_take) begin
         target_ff <= target_in;
         out_ff <= out_in;
         valid_ff <= valid_in;
         last_send_ff <= last_send_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/sspr_fifo.sv =====
// short job queue between the command front end and the frame serializer
`default_nettype none
module sspr_fifo #(
   parameter int DEPTH = 2
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire sspr_pkg::job_type push_job,
   output logic full,
   input wire logic pop,
   output logic empty,
   output sspr_pkg::job_type head_job
);
   import sspr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/sspr_back.sv =====
// frame serializer: turns queued jobs into result beats, one per cycle while beats are popped
`default_nettype none
module sspr_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic job_empty,
   input wire sspr_pkg::job_type job,
   output logic job_pop,
   input wire logic rsp_pop,
   output logic rsp_empty,
   output logic rsp_has_frame,
   output logic [7:0] rsp_frame_byte,
   output logic rsp_last,
   output logic signed [15:0] rsp_out_speed
);
   import sspr_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic valid_ff, valid_in;
   logic has_ff, has_in;
   logic [7:0] byte_ff, byte_in;
   logic last_ff, last_in;
   logic signed [15:0] speed_ff, speed_in;
   logic advance;

   // output stage moves when it is empty or its beat is taken
   assign advance = !valid_ff || rsp_pop;

   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff;
      has_in = has_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      speed_in = speed_ff;
      job_pop = 1'b0;
      if (advance) begin
         valid_in = !job_empty;
         if (!job_empty) begin
            has_in = job.has_frame;
            byte_in = job.has_frame ? frame_byte_at(job, idx_ff) : 8'd0;
            last_in = !job.has_frame || (idx_ff == LAST_IDX);
            speed_in = job.speed;
            job_pop = last_in;
            idx_in = last_in ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      has_ff <= has_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      speed_ff <= speed_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_has_frame = has_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last = last_ff;
   assign rsp_out_speed = speed_ff;

endmodule
`default_nettype wire

// ===== hdl/servo_speed_ramp_framer_top.sv =====
// Servo speed ramp framer. Commands (set target, set immediate, stop, ramp
// tick) are pushed in and decided combinationally by the front end, which
// keeps the target and output speeds and the keepalive timer. Each command
// leaves one job in a short queue; the serializer turns a job into ten frame
// beats (0x55 0x55 id 7 29 1 0 speed lo, speed hi, checksum) or a single beat
// with has_frame low, one beat per cycle while beats are popped, last set on
// the final beat. The serializer's beat rate sets the sustained throughput,
// and the front end keeps taking commands until the job queue fills.
// Configuration may be written only while no command is in flight.
`default_nettype none
module servo_speed_ramp_framer_top #(
   parameter int JOB_DEPTH = 2
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_wr_en,
   input wire logic [1:0] csr_addr,
   input wire logic [15:0] csr_wdata,
   input wire logic push,
   output logic full,
   input wire logic [1:0] req_opcode,
   input wire logic signed [15:0] req_speed,
   input wire logic [31:0] req_now_ms,
   output logic empty,
   input wire logic pop,
   output logic rsp_has_frame,
   output logic [7:0] rsp_frame_byte,
   output logic rsp_last,
   output logic signed [15:0] rsp_out_speed
);
   import sspr_pkg::*;

   job_type new_job, head_job;
   logic take, q_empty, q_pop;

   assign take = push && !full;

   sspr_front u_front (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .cmd_take(take),
      .cmd_opcode(req_opcode),
      .cmd_speed(req_speed),
      .cmd_now_ms(req_now_ms),
      .job(new_job)
   );

   sspr_fifo #(.DEPTH(JOB_DEPTH)) u_fifo (
      .clock(clock),
      .reset(reset),
      .push(take),
      .push_job(new_job),
      .full(full),
      .pop(q_pop),
      .empty(q_empty),
      .head_job(head_job)
   );

   sspr_back u_back (
      .clock(clock),
      .reset(reset),
      .job_empty(q_empty),
      .job(head_job),
      .job_pop(q_pop),
      .rsp_pop(pop),
      .rsp_empty(empty),
      .rsp_has_frame(rsp_has_frame),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last(rsp_last),
      .rsp_out_speed(rsp_out_speed)
   );

endmodule
`default_nettype wire
